[rtl/i2cmat_pkg.sv]
// Package for the multi-address I2C target: bus phases, event codes,
// register indexes, configuration and result records.
// No dependencies.
package i2cmat_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RX_ADDR,
        PH_RX_DATA,
        PH_TX_DATA,
        PH_TX_MACK,
        PH_IGNORE
    } phase_t;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_STOP  = 2'd1,
        EV_RISE  = 2'd2,
        EV_FALL  = 2'd3
    } bus_event_t;

    localparam logic [2:0] REG_KEY_ADDRESS   = 3'd0;
    localparam logic [2:0] REG_DIGIT_FIRST   = 3'd1;
    localparam logic [2:0] REG_DIGIT_LAST    = 3'd2;
    localparam logic [2:0] REG_KEY_RESPONSE  = 3'd3;

    localparam logic [3:0] BIT_BYTE_DONE = 4'd8;
    localparam logic [3:0] BIT_ACK_DONE  = 4'd9;

    typedef struct packed {
        logic [6:0] key_address;
        logic [6:0] digit_first;
        logic [6:0] digit_last;
        logic [7:0] key_response;
    } cfg_t;

    typedef struct packed {
        logic       key_read_done;
        logic [7:0] digit_segments;
        logic [6:0] digit_address;
        logic       digit_valid;
        logic       sda_pull_low;
    } result_t;

    function automatic logic in_digit_range(input cfg_t cfg, input logic [6:0] addr);
        return (addr >= cfg.digit_first) && (addr <= cfg.digit_last);
    endfunction

endpackage

[rtl/i2cmat_fsm.sv]
// Bit-level I2C target state machine: holds the transaction state and
// produces one result record per bus event. Depends on i2cmat_pkg.
module i2cmat_fsm
    import i2cmat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       event_en,
    input  bus_event_t bus_event,
    input  logic       sda_level,
    input  cfg_t       cfg,
    output result_t    result
);

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic [6:0] maddr_reg, maddr_next;
    logic       pull_reg, pull_next;
    logic       dpend_reg, dpend_next;
    logic [7:0] held_reg, held_next;

    logic       addr_ok;
    logic       key_read;

    assign addr_ok  = (shift_reg[7:1] == cfg.key_address)
                      || (!shift_reg[0] && in_digit_range(cfg, shift_reg[7:1]));
    assign key_read = (maddr_reg == cfg.key_address) && shift_reg[0];

    // next bus phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (bus_event)
            EV_START: phase_next = PH_RX_ADDR;
            EV_STOP:  phase_next = PH_IDLE;
            EV_RISE:  phase_next = phase_reg;
            EV_FALL:
            begin
                unique case (phase_reg)
                    PH_RX_ADDR:
                    begin
                        if (bit_cnt_reg == BIT_BYTE_DONE && !addr_ok)
                            phase_next = PH_IGNORE;
                        else if (bit_cnt_reg == BIT_ACK_DONE)
                            phase_next = key_read ? PH_TX_DATA : PH_RX_DATA;
                    end
                    PH_TX_DATA:
                    begin
                        if (!(bit_cnt_reg < BIT_BYTE_DONE))
                            phase_next = PH_TX_MACK;
                    end
                    PH_TX_MACK:
                    begin
                        if (bit_cnt_reg == 4'd1)
                            phase_next = PH_IGNORE;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
        endcase
    end

    // transaction data and result
    always_comb
    begin
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        maddr_next   = maddr_reg;
        pull_next    = pull_reg;
        dpend_next   = dpend_reg;
        held_next    = held_reg;
        result       = '0;
        unique case (bus_event)
            EV_START, EV_STOP:
            begin
                bit_cnt_next = '0;
                shift_next   = '0;
                maddr_next   = '0;
                pull_next    = 1'b0;
                dpend_next   = 1'b0;
                held_next    = '0;
            end
            EV_RISE:
            begin
                unique case (phase_reg)
                    PH_RX_ADDR, PH_RX_DATA:
                    begin
                        if (bit_cnt_reg < BIT_BYTE_DONE)
                        begin
                            shift_next   = {shift_reg[6:0], sda_level};
                            bit_cnt_next = bit_cnt_reg + 4'd1;
                        end
                        else if (bit_cnt_reg == BIT_BYTE_DONE)
                            bit_cnt_next = BIT_ACK_DONE;
                    end
                    PH_TX_DATA:
                    begin
                        if (bit_cnt_reg < BIT_BYTE_DONE)
                            bit_cnt_next = bit_cnt_reg + 4'd1;
                    end
                    PH_TX_MACK: bit_cnt_next = 4'd1;
                    default: ;
                endcase
            end
            EV_FALL:
            begin
                unique case (phase_reg)
                    PH_RX_ADDR:
                    begin
                        if (bit_cnt_reg == BIT_BYTE_DONE)
                        begin
                            maddr_next = shift_reg[7:1];
                            pull_next  = addr_ok;
                        end
                        else if (bit_cnt_reg == BIT_ACK_DONE)
                        begin
                            bit_cnt_next = '0;
                            if (key_read)
                                pull_next = !cfg.key_response[7];
                            else
                            begin
                                pull_next  = 1'b0;
                                shift_next = '0;
                            end
                        end
                    end
                    PH_RX_DATA:
                    begin
                        if (bit_cnt_reg == BIT_BYTE_DONE)
                        begin
                            pull_next = 1'b1;
                            if (in_digit_range(cfg, maddr_reg))
                            begin
                                dpend_next = 1'b1;
                                held_next  = shift_reg;
                            end
                        end
                        else if (bit_cnt_reg == BIT_ACK_DONE)
                        begin
                            pull_next = 1'b0;
                            if (dpend_reg)
                            begin
                                result.digit_valid    = 1'b1;
                                result.digit_address  = maddr_reg;
                                result.digit_segments = held_reg;
                            end
                            dpend_next   = 1'b0;
                            bit_cnt_next = '0;
                            shift_next   = '0;
                        end
                    end
                    PH_TX_DATA:
                    begin
                        // put the next response bit on the bus, MSB first
                        if (bit_cnt_reg < BIT_BYTE_DONE)
                            pull_next = !cfg.key_response[3'd7 - bit_cnt_reg[2:0]];
                        else
                        begin
                            pull_next    = 1'b0;
                            bit_cnt_next = '0;
                        end
                    end
                    PH_TX_MACK:
                    begin
                        if (bit_cnt_reg == 4'd1)
                        begin
                            result.key_read_done = 1'b1;
                            pull_next    = 1'b0;
                            bit_cnt_next = '0;
                        end
                    end
                    PH_IGNORE: pull_next = 1'b0;
                    default: ;
                endcase
            end
        endcase
        result.sda_pull_low = pull_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            maddr_reg   <= '0;
            pull_reg    <= 1'b0;
            dpend_reg   <= 1'b0;
            held_reg    <= '0;
        end
        else if (event_en)
        begin
            phase_reg   <= phase_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            maddr_reg   <= maddr_next;
            pull_reg    <= pull_next;
            dpend_reg   <= dpend_next;
            held_reg    <= held_next;
        end
    end

endmodule

[rtl/i2c_multi_address_target.sv]
// Multi-address I2C target: one bus event request in, one result out.
// A result goes to the output register, or to the skid entry on a stall.
// Throughput: one request per cycle while the skid entry is empty; it
// holds one result while another waits downstream. Reset (rst_n, async
// low): idle phase, outputs empty, FSM and config registers to defaults.
module i2c_multi_address_target
    import i2cmat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] sda_level, [7:1] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] sda_pull_low, [1] digit_valid,
                                   // [8:2] digit_address, [16:9] digit_segments,
                                   // [17] key_read_done, [23:18] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t    cfg_reg;
    result_t result;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    accept, pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign pop       = out_valid_reg && m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'd0, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_address  <= 7'h24;
            cfg_reg.digit_first  <= 7'h34;
            cfg_reg.digit_last   <= 7'h37;
            cfg_reg.key_response <= 8'h00;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KEY_ADDRESS:  cfg_reg.key_address  <= cfg_data[6:0];
                REG_DIGIT_FIRST:  cfg_reg.digit_first  <= cfg_data[6:0];
                REG_DIGIT_LAST:   cfg_reg.digit_last   <= cfg_data[6:0];
                REG_KEY_RESPONSE: cfg_reg.key_response <= cfg_data;
                default: ;
            endcase
        end
    end

    i2cmat_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .event_en  (accept),
        .bus_event (bus_event_t'(s_tuser)),
        .sda_level (s_tdata[0]),
        .cfg       (cfg_reg),
        .result    (result)
    );

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
            out_reg <= skid_valid_reg ? skid_reg : result;
        else if (accept)
            skid_reg <= result;
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_double_report: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[1] && m_tdata[17]))
        else $error("digit byte and key read reported together");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("accepted request lost while output stalled");

    a_digit_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[16:2] == 15'd0))
        else $error("digit fields set without digit_valid");

endmodule

[test/i2c_multi_address_target_tb.sv]
// Testbench for the multi-address I2C target: drives bus event requests and
// checks every result against a cycle-free model of the target kept here.
// Depends on rtl/i2cmat_pkg.sv and rtl/i2c_multi_address_target.sv.
`timescale 1ns / 100ps

module i2c_multi_address_target_tb;
    import i2cmat_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_GOAL   = 700;
    localparam int LONG_HOLD   = 80;
    localparam int SHOW_LIMIT  = 30;

    localparam logic [6:0] KEY_ADDRESS_RESET  = 7'h24;
    localparam logic [6:0] DIGIT_FIRST_RESET  = 7'h34;
    localparam logic [6:0] DIGIT_LAST_RESET   = 7'h37;
    localparam logic [7:0] KEY_RESPONSE_RESET = 8'h00;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    i2c_multi_address_target uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Tracks the target's transaction state and the results it must produce.
    class target_scoreboard;
        cfg_t       regs;
        phase_t     phase;
        logic [3:0] clock_count;
        logic [7:0] shift_reg;
        logic [6:0] peer_address;
        bit         drive_low;
        bit         segment_held;
        logic [7:0] segment_byte;
        result_t    awaited_results[$];
        int         errors;
        int         shown;

        function new();
            regs.key_address  = KEY_ADDRESS_RESET;
            regs.digit_first  = DIGIT_FIRST_RESET;
            regs.digit_last   = DIGIT_LAST_RESET;
            regs.key_response = KEY_RESPONSE_RESET;
            clear_bus(PH_IDLE);
            errors = 0;
            shown = 0;
        endfunction

        function void clear_bus(phase_t next);
            phase = next;
            clock_count = '0;
            shift_reg = '0;
            peer_address = '0;
            drive_low = 1'b0;
            segment_held = 1'b0;
            segment_byte = '0;
        endfunction

        function bit is_digit(logic [6:0] addr);
            return addr >= regs.digit_first && addr <= regs.digit_last;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void set_register(logic [2:0] idx, logic [7:0] val);
            case (idx)
                REG_KEY_ADDRESS:  regs.key_address = val[6:0];
                REG_DIGIT_FIRST:  regs.digit_first = val[6:0];
                REG_DIGIT_LAST:   regs.digit_last = val[6:0];
                REG_KEY_RESPONSE: regs.key_response = val;
                default: ;
            endcase
        endfunction

        function void note_bus_event(bus_event_t ev, logic sda);
            result_t res;
            res = '0;
            case (ev)
                EV_START: clear_bus(PH_RX_ADDR);
                EV_STOP:  clear_bus(PH_IDLE);
                EV_RISE:
                    case (phase)
                        PH_RX_ADDR, PH_RX_DATA:
                            if (clock_count < BIT_BYTE_DONE)
                            begin
                                shift_reg = {shift_reg[6:0], sda};
                                clock_count = clock_count + 4'd1;
                            end
                            else if (clock_count == BIT_BYTE_DONE)
                                clock_count = BIT_ACK_DONE;
                        PH_TX_DATA:
                            if (clock_count < BIT_BYTE_DONE)
                                clock_count = clock_count + 4'd1;
                        PH_TX_MACK:
                            clock_count = 4'd1;
                        default: ;
                    endcase
                default:
                    case (phase)
                        PH_RX_ADDR:
                            if (clock_count == BIT_BYTE_DONE)
                            begin
                                peer_address = shift_reg[7:1];
                                drive_low = (peer_address == regs.key_address) ||
                                            (!shift_reg[0] && is_digit(peer_address));
                                if (!drive_low)
                                    phase = PH_IGNORE;
                            end
                            else if (clock_count == BIT_ACK_DONE)
                            begin
                                clock_count = '0;
                                if (peer_address == regs.key_address && shift_reg[0])
                                begin
                                    phase = PH_TX_DATA;
                                    drive_low = !regs.key_response[7];
                                end
                                else
                                begin
                                    phase = PH_RX_DATA;
                                    shift_reg = '0;
                                    drive_low = 1'b0;
                                end
                            end
                        PH_RX_DATA:
                            if (clock_count == BIT_BYTE_DONE)
                            begin
                                drive_low = 1'b1;
                                if (is_digit(peer_address))
                                begin
                                    segment_held = 1'b1;
                                    segment_byte = shift_reg;
                                end
                            end
                            else if (clock_count == BIT_ACK_DONE)
                            begin
                                drive_low = 1'b0;
                                if (segment_held)
                                begin
                                    res.digit_valid = 1'b1;
                                    res.digit_address = peer_address;
                                    res.digit_segments = segment_byte;
                                end
                                segment_held = 1'b0;
                                clock_count = '0;
                                shift_reg = '0;
                            end
                        PH_TX_DATA:
                            // Present the next response bit, MSB first.
                            if (clock_count < BIT_BYTE_DONE)
                                drive_low = !regs.key_response[3'd7 - clock_count[2:0]];
                            else
                            begin
                                drive_low = 1'b0;
                                phase = PH_TX_MACK;
                                clock_count = '0;
                            end
                        PH_TX_MACK:
                            if (clock_count == 4'd1)
                            begin
                                res.key_read_done = 1'b1;
                                drive_low = 1'b0;
                                phase = PH_IGNORE;
                                clock_count = '0;
                            end
                        PH_IGNORE:
                            drive_low = 1'b0;
                        default: ;
                    endcase
            endcase
            res.sda_pull_low = drive_low;
            awaited_results.push_back(res);
        endfunction

        task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (shown < SHOW_LIMIT)
            begin
                shown++;
                $display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $time);
            end
        endtask

        task check_target_result(logic [23:0] data);
            result_t got;
            result_t want;
            got = data[17:0];
            if (awaited_results.size() == 0)
            begin
                report_mismatch("unrequested result", 32'd0, {8'd0, data});
                return;
            end
            want = awaited_results.pop_front();
            if (got.sda_pull_low !== want.sda_pull_low)
                report_mismatch("sda_pull_low", 32'(want.sda_pull_low),
                                32'(got.sda_pull_low));
            if (got.digit_valid !== want.digit_valid)
                report_mismatch("digit_valid", 32'(want.digit_valid), 32'(got.digit_valid));
            if (got.digit_address !== want.digit_address)
                report_mismatch("digit_address", 32'(want.digit_address),
                                32'(got.digit_address));
            if (got.digit_segments !== want.digit_segments)
                report_mismatch("digit_segments", 32'(want.digit_segments),
                                32'(got.digit_segments));
            if (got.key_read_done !== want.key_read_done)
                report_mismatch("key_read_done", 32'(want.key_read_done),
                                32'(got.key_read_done));
            if (data[23:18] !== 6'd0)
                report_mismatch("tdata padding", 32'd0, 32'(data[23:18]));
        endtask
    endclass

    target_scoreboard sb;

    int items_sent;
    int burst_left;
    int noise_pct;
    int hold_requests;
    bit gapless;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_bus_event(bus_event_t'(s_tuser), s_tdata[0]);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_target_result(m_tdata);
    end

    // Result sink: stall on a changing pattern, or hold off for long on request.
    initial
    begin : result_sink
        int mode;
        int span;
        int holds_served;
        mode = 0;
        span = 0;
        holds_served = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 96);
            end
            span--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 4) != 0);
                default: m_tready <= (span % 3 == 0);
            endcase
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one request; open a new burst after a random gap when one runs out.
    task automatic send_event(bus_event_t ev, bit sda);
        int gap;
        gap = 0;
        if (!gapless)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= ev;
        s_tdata <= {7'd0, sda};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Send one bus edge, now and then dropped, doubled or preceded by a stray one.
    task automatic bus_step(bus_event_t ev, bit sda);
        if ($urandom_range(0, 99) < noise_pct)
        begin
            case ($urandom_range(0, 2))
                0: return;
                1: send_event(ev, sda);
                default: send_event(bus_event_t'($urandom_range(0, 3)),
                                    1'($urandom_range(0, 1)));
            endcase
        end
        send_event(ev, sda);
    endtask

    // Eight data clocks MSB first, then the acknowledge clock.
    task automatic clock_byte(logic [7:0] value);
        for (int i = 7; i >= 0; i--)
        begin
            bus_step(EV_RISE, value[i]);
            bus_step(EV_FALL, 1'($urandom_range(0, 1)));
        end
        bus_step(EV_RISE, 1'($urandom_range(0, 1)));
        bus_step(EV_FALL, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_transaction();
        int pick;
        int nbytes;
        logic [6:0] addr;
        bit rw;
        logic [7:0] value;
        pick = $urandom_range(0, 99);
        noise_pct = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(3, 10);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 12))
                send_event(bus_event_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            addr = sb.regs.key_address;
            rw = 1'($urandom_range(0, 1));
        end
        else if (pick < 75 && sb.regs.digit_first <= sb.regs.digit_last)
        begin
            addr = 7'($urandom_range(sb.regs.digit_last, sb.regs.digit_first));
            rw = ($urandom_range(0, 99) < 15);
        end
        else
        begin
            addr = 7'($urandom_range(0, 127));
            rw = 1'($urandom_range(0, 1));
        end
        bus_step(EV_START, 1'($urandom_range(0, 1)));
        bus_step(EV_FALL, 1'($urandom_range(0, 1)));
        clock_byte({addr, rw});
        if (rw)
        begin
            clock_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0)
                clock_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            nbytes = $urandom_range(0, 3);
            repeat (nbytes)
            begin
                case ($urandom_range(0, 9))
                    0: value = 8'h00;
                    1: value = 8'hFF;
                    default: value = 8'($urandom_range(0, 255));
                endcase
                clock_byte(value);
            end
        end
        // Leave off the stop now and then so the next start is a repeated one.
        if ($urandom_range(0, 4) != 0)
            bus_step(EV_STOP, 1'($urandom_range(0, 1)));
    endtask

    // Pause the sender until every awaited result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, val);
    endtask

    task automatic configure(logic [7:0] key, logic [7:0] first, logic [7:0] last,
                             logic [7:0] response, bit touch_unused);
        settle();
        write_register(REG_KEY_ADDRESS, key);
        write_register(REG_DIGIT_FIRST, first);
        write_register(REG_DIGIT_LAST, last);
        write_register(REG_KEY_RESPONSE, response);
        if (touch_unused)
        begin
            for (int i = REG_KEY_RESPONSE + 1; i < 8; i++)
                write_register(3'(i), 8'($urandom_range(0, 255)));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int budget, bit squeeze);
        int target;
        target = items_sent + budget;
        if (squeeze)
        begin
            // Hold the sink off while requests keep coming back to back.
            hold_requests <= hold_requests + 1;
            gapless = 1'b1;
            run_transaction();
            run_transaction();
            gapless = 1'b0;
        end
        while (items_sent < target)
        begin
            run_transaction();
            if ($urandom_range(0, 19) == 0)
                settle();
        end
        settle();
    endtask

    initial
    begin : stimulus
        logic [7:0] first;
        logic [7:0] last;
        sb = new();
        items_sent = 0;
        burst_left = 0;
        noise_pct = 0;
        hold_requests = 0;
        gapless = 1'b0;
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= EV_STOP;
        cfg_valid <= 1'b0;
        cfg_index <= REG_KEY_ADDRESS;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Edges while idle, then an unanswered read and edges it must ignore.
        send_event(EV_STOP, 1'b0);
        send_event(EV_RISE, 1'b1);
        send_event(EV_FALL, 1'b1);
        send_event(EV_RISE, 1'b0);
        send_event(EV_START, 1'b1);
        send_event(EV_FALL, 1'b0);
        repeat (8)
        begin
            send_event(EV_RISE, 1'b1);
            send_event(EV_FALL, 1'b0);
        end
        send_event(EV_RISE, 1'b0);
        send_event(EV_FALL, 1'b1);
        send_event(EV_STOP, 1'b1);

        run_phase(100, 1'b0);
        configure(8'h00, 8'h00, 8'h7F, 8'hFF, 1'b0);
        run_phase(100, 1'b1);
        configure(8'hFF, 8'hFF, 8'h80, 8'h00, 1'b1);
        run_phase(100, 1'b0);
        configure(8'h55, 8'h55, 8'h55, 8'hA5, 1'b0);
        run_phase(100, 1'b0);
        configure(8'h7F, 8'h70, 8'h7F, 8'h5A, 1'b0);
        run_phase(100, 1'b0);

        while (items_sent < ITEM_GOAL)
        begin
            first = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                last = 8'($urandom_range(0, 255));
            else
                last = {1'($urandom_range(0, 1)), 7'(first[6:0] + $urandom_range(0, 8))};
            configure(8'($urandom_range(0, 255)), first, last, 8'($urandom_range(0, 255)),
                      $urandom_range(0, 7) == 0);
            run_phase(60, $urandom_range(0, 7) == 0);
        end

        settle();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
